// ----- hw/rtl/cap_pkg.sv -----
// Shared types, constants and helpers for the comb/all-pass room reverb.
package cap_pkg;

	// Sample and internal widths
	localparam int SAMPLE_W = 24;
	localparam int X_W      = 18;
	localparam int WET_W    = 28;

	// Q0.16 coefficients
	localparam logic signed [11:0] X_GAIN    = 12'sd983;
	localparam logic signed [17:0] DAMP_KEEP = 18'sd42598;
	localparam logic signed [17:0] DAMP_FB   = 18'sd22938;
	localparam logic [15:0]        FB_BASE   = 16'd45875;
	localparam logic [15:0]        FB_SLOPE  = 16'd17039;
	localparam logic [16:0]        SIZE_OFS  = 17'd32768;

	// Configuration register indexes
	localparam logic [1:0] REG_WET_MIX    = 2'd0;
	localparam logic [1:0] REG_ROOM_SIZE  = 2'd1;
	localparam logic [1:0] REG_RATE_RATIO = 2'd2;

	// Queue between front and back
	localparam int Q_DEPTH = 2;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] s;
		logic signed [X_W-1:0]      x;
		logic                       start;
		logic                       bypass;
	} item_t;

	typedef struct packed {
		logic  push;
		item_t item;
	} q_push_t;

	typedef struct packed {
		logic  empty;
		item_t item;
	} q_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_AP,
		ST_MUL,
		ST_FIN
	} back_state_t;

	// Base delay lengths at 44.1 kHz
	function automatic logic [10:0] comb_base(input logic [2:0] i);
		logic [10:0] b;
		unique case (i)
			3'd0: b = 11'd1116;
			3'd1: b = 11'd1188;
			3'd2: b = 11'd1277;
			3'd3: b = 11'd1356;
			3'd4: b = 11'd1422;
			3'd5: b = 11'd1491;
			3'd6: b = 11'd1557;
			default: b = 11'd1617;
		endcase
		return b;
	endfunction

	function automatic logic [10:0] ap_base(input logic [1:0] i);
		logic [10:0] b;
		unique case (i)
			2'd0: b = 11'd556;
			2'd1: b = 11'd441;
			2'd2: b = 11'd341;
			default: b = 11'd225;
		endcase
		return b;
	endfunction

	// Saturate to 24 bit signed
	function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [47:0] v);
		logic signed [SAMPLE_W-1:0] r;
		if (v > 48'sd8388607) begin
			r = 24'sh7fffff;
		end else if (v < -48'sd8388608) begin
			r = 24'sh800000;
		end else begin
			r = v[SAMPLE_W-1:0];
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/comb_allpass_room_reverb_top.sv -----
// Room reverb top level: eight damped combs into four series all-passes.
// Each item is popped from the queue, then passes the serial comb issue, the comb pipeline drain,
// the all-pass chain, the wet-mix multiply and the output register; bypass goes straight to output.
// The back end takes a new item only once the last one is loaded into the output register.
// Reset and each register write run the length unit with in_stall high; delay memories use
// per-line fill marks and need no clearing pass.
module comb_allpass_room_reverb_top import cap_pkg::*; #(
	parameter int COMB_DEPTH    = 8192,
	parameter int ALLPASS_DEPTH = 2048,
	parameter int NUM_COMBS     = 8,
	parameter int NUM_ALLPASSES = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	input  logic                       start_req,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] sample_out,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [15:0]                cfg_data
);

	localparam int CLW = $clog2(COMB_DEPTH + 1);
	localparam int ALW = $clog2(ALLPASS_DEPTH + 1);

	logic           bypass, busy, q_full, pop;
	logic [15:0]    fb;
	logic [18:0]    mix5;
	logic [CLW-1:0] comb_len [NUM_COMBS];
	logic [ALW-1:0] ap_len [NUM_ALLPASSES];
	q_push_t        qp;
	q_stat_t        qs;

	cap_cfg #(
		.NC(NUM_COMBS), .NA(NUM_ALLPASSES), .CD(COMB_DEPTH), .AD(ALLPASS_DEPTH),
		.CLW(CLW), .ALW(ALW)
	) u_cfg (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.bypass, .busy, .fb, .mix5, .comb_len, .ap_len
	);

	cap_front u_front (
		.in_valid, .in_stall, .sample_in, .start_req, .busy, .bypass, .q_full, .qp
	);

	cap_queue u_queue (
		.clk, .arst_n, .qp, .pop, .full(q_full), .qs
	);

	cap_back #(
		.NC(NUM_COMBS), .NA(NUM_ALLPASSES), .CD(COMB_DEPTH), .AD(ALLPASS_DEPTH),
		.CLW(CLW), .ALW(ALW)
	) u_back (
		.clk, .arst_n, .qs, .pop, .fb, .mix5, .comb_len, .ap_len,
		.out_valid, .out_stall, .sample_out
	);

endmodule

// ----- hw/rtl/cap_cfg.sv -----
// Configuration registers, feedback/mix coefficients and delay length unit.
module cap_cfg import cap_pkg::*; #(
	parameter int NC  = 8,
	parameter int NA  = 4,
	parameter int CD  = 8192,
	parameter int AD  = 2048,
	parameter int CLW = $clog2(CD + 1),
	parameter int ALW = $clog2(AD + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [1:0]     cfg_index,
	input  logic [15:0]    cfg_data,
	output logic           bypass,
	output logic           busy,
	output logic [15:0]    fb,
	output logic [18:0]    mix5,
	output logic [CLW-1:0] comb_len [NC],
	output logic [ALW-1:0] ap_len [NA]
);

	localparam int LCW = $clog2(NC + NA + 1);

	logic [15:0]    wet_mix_q, room_size_q, rate_ratio_q;
	logic           busy_q;
	logic [LCW-1:0] cnt_q;
	logic [32:0]    scale_q;
	logic [15:0]    fb_q;
	logic [18:0]    mix5_q;
	logic           wr;
	logic [LCW-1:0] k;
	logic [10:0]    base;
	logic [43:0]    prod;
	logic [13:0]    raw;
	logic [CLW-1:0] cl;
	logic [ALW-1:0] al;

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid && (cfg_index == REG_WET_MIX || cfg_index == REG_ROOM_SIZE
		|| cfg_index == REG_RATE_RATIO);
	assign bypass    = (wet_mix_q == 16'd0);
	assign busy      = busy_q;
	assign fb        = fb_q;
	assign mix5      = mix5_q;

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wet_mix_q    <= 16'd0;
			room_size_q  <= 16'd32768;
			rate_ratio_q <= 16'd16384;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_WET_MIX:    wet_mix_q    <= cfg_data;
				REG_ROOM_SIZE:  room_size_q  <= cfg_data;
				REG_RATE_RATIO: rate_ratio_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Derived coefficients
	always_ff @(posedge clk) begin
		scale_q <= 33'(rate_ratio_q) * 33'(SIZE_OFS + 17'(room_size_q));
		fb_q    <= FB_BASE + 16'((32'(FB_SLOPE) * 32'(room_size_q)) >> 16);
		mix5_q  <= 19'(wet_mix_q) * 19'd5;
	end

	// One length per cycle
	always_comb begin
		k = cnt_q - LCW'(1);
		if (32'(k) < NC) begin
			base = comb_base(3'(k));
		end else begin
			base = ap_base(2'(32'(k) - NC));
		end
		prod = 44'(scale_q) * 44'(base);
		raw  = prod[43:30];
		if (raw == 14'd0) begin
			cl = CLW'(1);
			al = ALW'(1);
		end else begin
			cl = (32'(raw) > CD) ? CLW'(CD) : CLW'(raw);
			al = (32'(raw) > AD) ? ALW'(AD) : ALW'(raw);
		end
	end

	// Length sequencer: restarts on reset and every register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (wr) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (32'(cnt_q) == NC + NA) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + LCW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NC; i++) begin
			if (busy_q && 32'(cnt_q) == i + 1) begin
				comb_len[i] <= cl;
			end
		end
		for (int i = 0; i < NA; i++) begin
			if (busy_q && 32'(cnt_q) == NC + i + 1) begin
				ap_len[i] <= al;
			end
		end
	end

endmodule

// ----- hw/rtl/cap_front.sv -----
// Front end: accepts input beats, scales the comb input and classifies bypass.
module cap_front import cap_pkg::*; (
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	input  logic                       start_req,
	input  logic                       busy,
	input  logic                       bypass,
	input  logic                       q_full,
	output q_push_t                    qp
);

	logic signed [34:0] xp;

	always_comb begin
		in_stall       = busy | q_full;
		xp             = 35'(sample_in) * 35'(X_GAIN);
		qp.push        = in_valid & ~in_stall;
		qp.item.s      = sample_in;
		qp.item.x      = X_W'(xp >>> 16);
		qp.item.start  = start_req;
		qp.item.bypass = bypass;
	end

endmodule

// ----- hw/rtl/cap_queue.sv -----
// Short FIFO between front and back.
module cap_queue import cap_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  q_push_t qp,
	input  logic    pop,
	output logic    full,
	output q_stat_t qs
);

	localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

	item_t         mem_q [Q_DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [PW:0]   cnt_q;

	assign full     = (32'(cnt_q) == Q_DEPTH);
	assign qs.empty = (cnt_q == '0);
	assign qs.item  = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (qp.push) begin
				wptr_q <= (32'(wptr_q) == Q_DEPTH - 1) ? '0 : wptr_q + PW'(1);
			end
			if (pop) begin
				rptr_q <= (32'(rptr_q) == Q_DEPTH - 1) ? '0 : rptr_q + PW'(1);
			end
			cnt_q <= cnt_q + (PW+1)'(qp.push) - (PW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (qp.push) begin
			mem_q[wptr_q] <= qp.item;
		end
	end

endmodule

// ----- hw/rtl/cap_back.sv -----
// Back end: comb pipeline, all-pass chain, wet mix and output register.
module cap_back import cap_pkg::*; #(
	parameter int NC  = 8,
	parameter int NA  = 4,
	parameter int CD  = 8192,
	parameter int AD  = 2048,
	parameter int CLW = $clog2(CD + 1),
	parameter int ALW = $clog2(AD + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  q_stat_t                    qs,
	output logic                       pop,
	input  logic [15:0]                fb,
	input  logic [18:0]                mix5,
	input  logic [CLW-1:0]             comb_len [NC],
	input  logic [ALW-1:0]             ap_len [NA],
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] sample_out
);

	localparam int CPW = $clog2(CD);
	localparam int APW = $clog2(AD);
	localparam int CAW = $clog2(NC * CD);
	localparam int AAW = $clog2(NA * AD);
	localparam int CIW = (NC > 1) ? $clog2(NC) : 1;
	localparam int AIW = (NA > 1) ? $clog2(NA) : 1;
	localparam int ISS = (NC > NA) ? NC : NA;
	localparam int ICW = $clog2(ISS + 1);

	typedef logic signed [SAMPLE_W-1:0] smp_t;

	// Delay memories
	smp_t cmem [NC * CD];
	smp_t amem [NA * AD];
	smp_t crow_q, arow_q;

	back_state_t state_q, state_d;
	logic [ICW-1:0] cnt_q;
	logic [AIW-1:0] j_q;

	// Per-line positions, fill marks and damping stores
	logic [CPW-1:0] cpos_q [NC];
	logic [CLW-1:0] chw_q [NC];
	smp_t           cdmp_q [NC];
	logic [APW-1:0] apos_q [NA];
	logic [ALW-1:0] ahw_q [NA];
	logic [AAW-1:0] apa_q [NA];
	smp_t           apd_q [NA];

	// Item registers
	smp_t                    s_q;
	logic signed [X_W-1:0]   x_q;
	logic                    byp_q;
	logic signed [WET_W-1:0] wet_q;
	logic signed [47:0]      prod_q;
	logic                    out_valid_q;
	smp_t                    out_q;

	// Comb pipeline
	logic                v_s1, v_s2, v_s3, v_s4;
	logic [CIW-1:0]      idx_s1, idx_s2;
	logic                hit_s1;
	logic [CAW-1:0]      addr_s1, addr_s2, addr_s3, addr_s4;
	logic signed [41:0]  m1_s2, m2_s2;
	smp_t                d_s2, dn_s3;
	logic signed [40:0]  pf_s4;

	// All-pass read capture
	logic           a_v1, a_hit1;
	logic [AIW-1:0] a_j1;

	// Control
	logic            c_rd, a_rd, ap_we, load_out, clr;
	logic [CIW-1:0]  ci;
	logic [AIW-1:0]  ai;
	logic [CAW-1:0]  craddr;
	logic [AAW-1:0]  araddr;
	logic [CPW:0]    cnext;
	logic [APW:0]    anext;
	logic            chit, ahit;
	smp_t            d1, dn, cwd, ad, awd;
	logic signed [WET_W-1:0] ao;
	logic signed [42:0]      dsum;
	smp_t            y;

	assign out_valid  = out_valid_q;
	assign sample_out = out_q;

	// Next state and strobes
	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		c_rd     = 1'b0;
		a_rd     = 1'b0;
		ap_we    = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!qs.empty) begin
					pop     = 1'b1;
					state_d = qs.item.bypass ? ST_FIN : ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				c_rd = (32'(cnt_q) < NC);
				a_rd = (32'(cnt_q) < NA);
				if (32'(cnt_q) == ISS - 1) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!v_s1 && !v_s2 && !v_s3 && !v_s4) begin
					state_d = ST_AP;
				end
			end
			ST_AP: begin
				ap_we = 1'b1;
				if (32'(j_q) == NA - 1) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign clr = pop && qs.item.start;

	// Issue addressing; a read past the fill mark sees zero
	always_comb begin
		ci     = CIW'(cnt_q);
		ai     = AIW'(cnt_q);
		craddr = CAW'(CAW'(ci) * CAW'(CD)) + CAW'(cpos_q[ci]);
		araddr = AAW'(AAW'(ai) * AAW'(AD)) + AAW'(apos_q[ai]);
		cnext  = {1'b0, cpos_q[ci]} + (CPW+1)'(1);
		anext  = {1'b0, apos_q[ai]} + (APW+1)'(1);
		chit   = 32'(cpos_q[ci]) < 32'(chw_q[ci]);
		ahit   = 32'(apos_q[ai]) < 32'(ahw_q[ai]);
	end

	// Datapath arithmetic
	always_comb begin
		d1   = hit_s1 ? crow_q : '0;
		dsum = 43'(m1_s2) + 43'(m2_s2);
		dn   = sat24(48'(dsum >>> 16));
		cwd  = sat24(48'(x_q) + 48'(pf_s4 >>> 16));
		ad   = apd_q[j_q];
		ao   = WET_W'(29'(ad) - 29'(wet_q));
		awd  = sat24(48'(wet_q) + 48'(ad >>> 1));
		y    = byp_q ? s_q : sat24(48'(s_q) + (prod_q >>> 17));
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			j_q         <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			a_v1        <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NC; i++) begin
				cpos_q[i] <= '0;
				chw_q[i]  <= '0;
				cdmp_q[i] <= '0;
			end
			for (int i = 0; i < NA; i++) begin
				apos_q[i] <= '0;
				ahw_q[i]  <= '0;
			end
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_q == ST_ISSUE) ? cnt_q + ICW'(1) : '0;
			j_q     <= (state_q == ST_AP) ? j_q + AIW'(1) : '0;
			v_s1    <= c_rd;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			a_v1    <= a_rd;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (clr) begin
				for (int i = 0; i < NC; i++) begin
					cpos_q[i] <= '0;
					chw_q[i]  <= '0;
					cdmp_q[i] <= '0;
				end
				for (int i = 0; i < NA; i++) begin
					apos_q[i] <= '0;
					ahw_q[i]  <= '0;
				end
			end else begin
				if (c_rd) begin
					cpos_q[ci] <= (32'(cnext) >= 32'(comb_len[ci])) ? '0 : CPW'(cnext);
					if (32'(cnext) > 32'(chw_q[ci])) begin
						chw_q[ci] <= CLW'(cnext);
					end
				end
				if (a_rd) begin
					apos_q[ai] <= (32'(anext) >= 32'(ap_len[ai])) ? '0 : APW'(anext);
					if (32'(anext) > 32'(ahw_q[ai])) begin
						ahw_q[ai] <= ALW'(anext);
					end
				end
				if (v_s2) begin
					cdmp_q[idx_s2] <= dn;
				end
			end
		end
	end

	// Payload pipeline
	always_ff @(posedge clk) begin
		if (pop) begin
			s_q   <= qs.item.s;
			x_q   <= qs.item.x;
			byp_q <= qs.item.bypass;
			wet_q <= '0;
		end else if (v_s2) begin
			wet_q <= wet_q + WET_W'(d_s2);
		end else if (ap_we) begin
			wet_q <= ao;
		end
		// s1 -> s2: damping products
		idx_s1  <= ci;
		hit_s1  <= chit;
		addr_s1 <= craddr;
		idx_s2  <= idx_s1;
		addr_s2 <= addr_s1;
		d_s2    <= d1;
		m1_s2   <= 42'(d1) * 42'(DAMP_KEEP);
		m2_s2   <= 42'(cdmp_q[idx_s1]) * 42'(DAMP_FB);
		// s2 -> s3 -> s4: feedback product
		dn_s3   <= dn;
		addr_s3 <= addr_s2;
		pf_s4   <= 41'(dn_s3) * 41'($signed({1'b0, fb}));
		addr_s4 <= addr_s3;
		// all-pass read capture
		a_j1    <= ai;
		a_hit1  <= ahit;
		if (a_rd) begin
			apa_q[ai] <= araddr;
		end
		if (a_v1) begin
			apd_q[a_j1] <= a_hit1 ? arow_q : '0;
		end
		if (state_q == ST_MUL) begin
			prod_q <= 48'(wet_q) * 48'($signed({1'b0, mix5}));
		end
		if (load_out) begin
			out_q <= y;
		end
	end

	// Comb delay memory
	always_ff @(posedge clk) begin
		if (c_rd) begin
			crow_q <= cmem[craddr];
		end
		if (v_s4) begin
			cmem[addr_s4] <= cwd;
		end
	end

	// All-pass delay memory
	always_ff @(posedge clk) begin
		if (a_rd) begin
			arow_q <= amem[araddr];
		end
		if (ap_we) begin
			amem[apa_q[j_q]] <= awd;
		end
	end

endmodule
